### rtl/ates_pkg.sv
// shared types and character codes for the terminal screen engine
package ates_pkg;

  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_READ = 1'b1;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7e;

  localparam logic [7:0] CMD_C     = 8'h43;
  localparam logic [7:0] CMD_H     = 8'h48;
  localparam logic [7:0] CMD_J     = 8'h4a;
  localparam logic [7:0] CMD_F     = 8'h66;

  localparam logic [1:0] BM_EMPTY  = 2'd0;
  localparam logic [1:0] BM_TWO    = 2'd1;
  localparam logic [1:0] BM_OTHER  = 2'd2;

  localparam logic [15:0] COL_MAX  = 16'hffff;

  typedef struct packed {
    logic        consumed;
    logic        esc_open;
    logic        clear;
    logic        place;
    logic        right;
    logic [15:0] row_arg;
    logic [15:0] col_arg;
  } esc_cmd_t;

endpackage

### rtl/ates_ram.sv
// generic single-clock ram with one write port and one registered read port
module ates_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1152
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ates_esc_parser.sv
// escape sequence collector and parameter decoder
module ates_esc_parser import ates_pkg::*; #(
  parameter int unsigned ESC_MAX = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_en,
  input  logic [7:0] byte_value,
  output esc_cmd_t cmd
);

  localparam int unsigned LEN_W = $clog2(ESC_MAX + 1);

  logic             active_r,  active_nxt;
  logic [LEN_W-1:0] len_r,     len_nxt;
  logic             bracket_r, bracket_nxt;
  logic [15:0]      accum_r,   accum_nxt;
  logic [1:0]       flags_r,   flags_nxt;
  logic [1:0]       pd_r,      pd_nxt;
  logic [15:0]      first_r,   first_nxt;
  logic [15:0]      second_r,  second_nxt;
  logic [1:0]       bm_r,      bm_nxt;

  logic [15:0]      part_val;
  logic [15:0]      cl_first;
  logic [15:0]      cl_second;
  logic [1:0]       cl_pd;
  logic [20:0]      acc_ext;
  logic [LEN_W:0]   len_inc;
  logic             is_final;
  logic             is_digit;
  logic [15:0]      right_amt;

  // closing the current part
  always_comb begin
    part_val  = flags_r[1] ? 16'd0 : accum_r;
    cl_first  = first_r;
    cl_second = second_r;
    cl_pd     = pd_r;
    if (flags_r[0]) begin
      if (pd_r == 2'd0) begin
        cl_first = part_val;
      end else if (pd_r == 2'd1) begin
        cl_second = part_val;
      end
      if (pd_r < 2'd2) begin
        cl_pd = pd_r + 2'd1;
      end
    end
  end

  assign acc_ext  = 21'({accum_r, 3'b000}) + 21'({accum_r, 1'b0}) +
                    21'(byte_value - CH_ZERO);
  assign len_inc  = {1'b0, len_r} + (LEN_W+1)'(1);
  assign is_final = (byte_value >= FINAL_LO) && (byte_value <= FINAL_HI);
  assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign right_amt = (cl_pd >= 2'd1) ? cl_first : 16'd0;

  always_comb begin
    active_nxt  = active_r;
    len_nxt     = len_r;
    bracket_nxt = bracket_r;
    accum_nxt   = accum_r;
    flags_nxt   = flags_r;
    pd_nxt      = pd_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    bm_nxt      = bm_r;
    cmd         = '0;

    if (byte_en) begin
      if (active_r) begin
        cmd.consumed = 1'b1;
        len_nxt      = len_inc[LEN_W-1:0];
        if (len_inc == (LEN_W+1)'(1)) begin
          bracket_nxt = (byte_value == CH_LBRACK);
        end else if (is_final || (len_inc > (LEN_W+1)'(ESC_MAX))) begin
          if (is_final && bracket_r) begin
            priority if (byte_value == CMD_J) begin
              cmd.clear = (bm_r == BM_TWO);
            end else if ((byte_value == CMD_H) || (byte_value == CMD_F)) begin
              cmd.place   = 1'b1;
              cmd.row_arg = ((cl_pd >= 2'd1) && (cl_first != 16'd0)) ?
                            cl_first - 16'd1 : 16'd0;
              cmd.col_arg = ((cl_pd >= 2'd2) && (cl_second != 16'd0)) ?
                            cl_second - 16'd1 : 16'd0;
            end else if (byte_value == CMD_C) begin
              cmd.right   = 1'b1;
              cmd.col_arg = (right_amt == 16'd0) ? 16'd1 : right_amt;
            end else begin
            end
          end
          active_nxt  = 1'b0;
          len_nxt     = '0;
          bracket_nxt = 1'b0;
          accum_nxt   = '0;
          flags_nxt   = '0;
          pd_nxt      = '0;
          first_nxt   = '0;
          second_nxt  = '0;
          bm_nxt      = BM_EMPTY;
        end else if (byte_value != CH_QMARK) begin
          bm_nxt = ((bm_r == BM_EMPTY) && (byte_value == CH_TWO)) ? BM_TWO : BM_OTHER;
          if (byte_value == CH_SEMI) begin
            first_nxt  = cl_first;
            second_nxt = cl_second;
            pd_nxt     = cl_pd;
            accum_nxt  = '0;
            flags_nxt  = '0;
          end else begin
            flags_nxt[0] = 1'b1;
            if (is_digit) begin
              accum_nxt = (acc_ext > 21'(COL_MAX)) ? COL_MAX : acc_ext[15:0];
            end else begin
              flags_nxt[1] = 1'b1;
            end
          end
        end
      end else if (byte_value == CH_ESC) begin
        cmd.consumed = 1'b1;
        active_nxt   = 1'b1;
        len_nxt      = '0;
        bracket_nxt  = 1'b0;
        accum_nxt    = '0;
        flags_nxt    = '0;
        pd_nxt       = '0;
        first_nxt    = '0;
        second_nxt   = '0;
        bm_nxt       = BM_EMPTY;
      end
    end
    cmd.esc_open = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      len_r     <= '0;
      bracket_r <= 1'b0;
      accum_r   <= '0;
      flags_r   <= '0;
      pd_r      <= '0;
      first_r   <= '0;
      second_r  <= '0;
      bm_r      <= BM_EMPTY;
    end else if (byte_en) begin
      active_r  <= active_nxt;
      len_r     <= len_nxt;
      bracket_r <= bracket_nxt;
      accum_r   <= accum_nxt;
      flags_r   <= flags_nxt;
      pd_r      <= pd_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      bm_r      <= bm_nxt;
    end
  end

endmodule

### rtl/ansi_terminal_screen_engine.sv
// top level of the terminal screen engine: cursor, screen ram and result register
//
// Input channel (in_valid/in_ready) carries one item per transfer: a stream
// byte (in_kind 0) or a cell read (in_kind 1). The result channel
// (out_valid/out_ready) returns exactly one result per item: the cell
// character (0 for stream bytes or reads off the screen), the cursor after
// the item and whether an escape sequence is open.
// A stream byte's result is registered at the edge that takes the byte, so
// bytes go at one per cycle while the receiver keeps up.
// A read waits in ST_READ for the registered read port of the screen
// ram, and no new item is taken until its result is registered.
// After reset, and after a clear-screen sequence, the screen ram is swept to
// spaces one cell a cycle, all ROWS*COLS cells (1152 at the defaults), while
// in_ready stays low.
// A pending result waits in the output register while out_ready is low; a
// new item is taken only once that register is free or drains in the same
// cycle.
module ansi_terminal_screen_engine import ates_pkg::*; #(
  parameter int unsigned ROWS    = 12,
  parameter int unsigned COLS    = 96,
  parameter int unsigned ESC_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_byte_value,
  input  logic [3:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_cell_char,
  output logic [3:0]  out_cursor_row,
  output logic [15:0] out_cursor_col,
  output logic        out_escape_open
);

  localparam int unsigned DEPTH  = ROWS * COLS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_W  = $clog2(COLS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [15:0]       cur_col_r, cur_col_nxt;
  logic              out_valid_r;
  logic [7:0]        out_cell_r;
  logic [3:0]        out_row_r;
  logic [15:0]       out_col_r;
  logic              out_esc_r;
  logic              read_oob_r;

  logic              fire;
  logic              byte_fire;
  logic              read_fire;
  esc_cmd_t          cmd;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              rd_in_range;
  logic              byte_write;
  logic [16:0]       col_sum;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign fire      = in_valid && in_ready;
  assign byte_fire = fire && (in_kind == KIND_BYTE);
  assign read_fire = fire && (in_kind == KIND_READ);

  ates_esc_parser #(
    .ESC_MAX (ESC_MAX)
  ) u_esc (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (byte_fire),
    .byte_value (in_byte_value),
    .cmd        (cmd)
  );

  assign col_sum = {1'b0, cur_col_r} + {1'b0, cmd.col_arg};

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    state_nxt   = state_r;
    byte_write  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (read_fire) begin
          state_nxt = ST_READ;
        end else if (byte_fire) begin
          if (cmd.consumed) begin
            if (cmd.clear) begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              state_nxt   = ST_CLEAR;
            end else if (cmd.place) begin
              cur_row_nxt = (cmd.row_arg > 16'(ROWS - 1)) ? ROW_W'(ROWS - 1) :
                            ROW_W'(cmd.row_arg);
              cur_col_nxt = cmd.col_arg;
            end else if (cmd.right) begin
              cur_col_nxt = col_sum[16] ? COL_MAX : col_sum[15:0];
            end
          end else if (in_byte_value == CH_CR) begin
            cur_col_nxt = '0;
          end else if (in_byte_value == CH_LF) begin
            cur_row_nxt = (cur_row_r < ROW_W'(ROWS - 1)) ? cur_row_r + ROW_W'(1) :
                          ROW_W'(ROWS - 1);
            cur_col_nxt = '0;
          end else if ((in_byte_value >= CH_SPACE) && (in_byte_value != CH_DEL)) begin
            byte_write  = (cur_col_r < 16'(COLS));
            cur_col_nxt = (cur_col_r == COL_MAX) ? COL_MAX : cur_col_r + 16'd1;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // screen ram ports
  assign ram_we    = (state_r == ST_CLEAR) || byte_write;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r :
                     ADDR_W'(32'(cur_row_r) * COLS + 32'(cur_col_r[COL_W-1:0]));
  assign ram_wdata = (state_r == ST_CLEAR) ? CH_SPACE : in_byte_value;
  assign ram_raddr = ADDR_W'(32'(in_read_row) * COLS + 32'(in_read_col));
  assign rd_in_range = (7'(in_read_row) < 7'(ROWS)) && (9'(in_read_col) < 9'(COLS));

  ates_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (read_fire),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end else begin
        clr_addr_r <= '0;
      end
      if (byte_fire || (state_r == ST_READ)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (read_fire) begin
      read_oob_r <= !rd_in_range;
    end
    if (byte_fire) begin
      out_cell_r <= 8'd0;
      out_row_r  <= 4'(cur_row_nxt);
      out_col_r  <= cur_col_nxt;
      out_esc_r  <= cmd.esc_open;
    end else if (read_fire) begin
      out_row_r  <= 4'(cur_row_r);
      out_col_r  <= cur_col_r;
      out_esc_r  <= cmd.esc_open;
    end else if (state_r == ST_READ) begin
      out_cell_r <= read_oob_r ? 8'd0 : ram_rdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_char   = out_cell_r;
  assign out_cursor_row  = out_row_r;
  assign out_cursor_col  = out_col_r;
  assign out_escape_open = out_esc_r;

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_row_r <= ROW_W'(ROWS - 1))
    else $error("cursor row beyond last row");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < DEPTH))
    else $error("screen write outside the store");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    read_fire |=> (state_r == ST_READ) ##1 out_valid_r)
    else $error("read transfer did not produce a result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while reading or clearing");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_fire && cmd.clear) |=> (cur_row_r == '0) && (cur_col_r == 16'd0))
    else $error("clear did not home the cursor");

endmodule
